// ----- rtl/core/vtke_pkg.sv -----
// Shared types, constants and helpers for the vblank time Kalman estimator.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package vtke_pkg;

  // Defaults of the top-level parameters
  localparam int TIME_BITS_DEF      = 63;
  localparam int GAIN_FRAC_BITS_DEF = 31;

  // Word field widths
  localparam int CMD_W    = 2;
  localparam int TIME_W   = 63;
  localparam int RESID_W  = 31;
  localparam int PERIOD_W = 30;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MEASURED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MISSED   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_INITIAL_PERIOD = 2'd0;
  localparam logic [1:0] REG_NOISE_PHASE    = 2'd1;
  localparam logic [1:0] REG_NOISE_PERIOD   = 2'd2;
  localparam logic [1:0] REG_MEAS_NOISE     = 2'd3;

  // Register reset values
  localparam logic [29:0] RST_INITIAL_PERIOD = 30'd16666667;
  localparam logic [39:0] RST_NOISE_PHASE    = 40'd2500;
  localparam logic [39:0] RST_NOISE_PERIOD   = 40'd400;
  localparam logic [49:0] RST_MEAS_NOISE     = 50'd22500000000;

  // Reciprocal of ten: (x * DIV10_MULT) >> DIV10_SHIFT is x / 10 for 32-bit x
  localparam logic [31:0] DIV10_MULT  = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // Divider operand select
  localparam logic [2:0] DSEL_K0 = 3'd0;
  localparam logic [2:0] DSEL_K1 = 3'd1;

  // Multiplier operand select: gain times value, and where the result goes
  localparam logic [2:0] MSEL_K0_Y   = 3'd0;
  localparam logic [2:0] MSEL_K1_Y   = 3'd1;
  localparam logic [2:0] MSEL_K0_HPP = 3'd2;
  localparam logic [2:0] MSEL_K0_HPR = 3'd3;
  localparam logic [2:0] MSEL_K1_HPP = 3'd4;
  localparam logic [2:0] MSEL_K1_HPR = 3'd5;

  typedef struct packed {
    logic [29:0] initial_period_ns;
    logic [39:0] process_noise_phase;
    logic [39:0] process_noise_period;
    logic [49:0] measurement_noise;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_START0, ST_START1, ST_START2,
    ST_PRED0, ST_PRED1, ST_PRED2, ST_PRED3, ST_MISS, ST_MEAS,
    ST_DIV_INIT, ST_DIV_STEP, ST_DIV_END,
    ST_MUL_INIT, ST_MUL_STEP, ST_MUL_END, ST_RESID, ST_OUT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START0, OP_START1, OP_START2,
    OP_PRED0, OP_PRED1, OP_PRED2, OP_PRED3, OP_MISS, OP_MEAS,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
    OP_MUL_INIT, OP_MUL_STEP, OP_MUL_END, OP_RESID, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             out_free;
  } dp_stat_t;

  // Signed 64-bit add that saturates
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sadd = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sadd = s[63:0];
    end
  endfunction

  // Magnitude of a signed 64-bit value
  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    mag64 = a[63] ? (~a + 64'd1) : a;
  endfunction

endpackage

// ----- rtl/core/vtke_item_if.sv -----
// Input channel: one command word with its timestamp.
// Depends on vtke_pkg for field widths.
`timescale 1ns / 1ps

interface vtke_item_if;
  logic                        valid;
  logic                        ready;
  logic [vtke_pkg::CMD_W-1:0]  cmd;
  logic [vtke_pkg::TIME_W-1:0] vblank_time_ns;

  modport source (output valid, output cmd, output vblank_time_ns, input ready);
  modport sink (input valid, input cmd, input vblank_time_ns, output ready);
endinterface

// ----- rtl/core/vtke_result_if.sv -----
// Output channel: predicted vblank, residual and period.
// Depends on vtke_pkg for field widths.
`timescale 1ns / 1ps

interface vtke_result_if;
  logic                               valid;
  logic                               ready;
  logic [vtke_pkg::TIME_W-1:0]        predicted_next_ns;
  logic signed [vtke_pkg::RESID_W-1:0] residual_ns;
  logic [vtke_pkg::PERIOD_W-1:0]      period_ns;

  modport source (output valid, output predicted_next_ns, output residual_ns,
                  output period_ns, input ready);
  modport sink (input valid, input predicted_next_ns, input residual_ns,
                input period_ns, output ready);
endinterface

// ----- rtl/core/vblank_time_kalman_estimator.sv -----
// Top level of the vblank time Kalman estimator: register file and wiring
// of sequencer and datapath. Depends on vtke_pkg, the two channel
// interfaces, vtke_ctrl and vtke_dpath.
//
//   channel   role    words                                   handshake
//   items     sink    cmd, vblank_time_ns                     valid/ready
//   results   source  predicted_next_ns, residual_ns, period  valid/ready
//   apb       slave   4 registers at 8*i, 64-bit data         psel/penable
//
// One word at a time. Start seeds the state, missed only predicts, an unused command
// goes straight to the output, and measured runs prediction, the bit-serial gain divider,
// the bit-serial gain multiplier and the residual.
// Synchronous reset clears filter state and registers to their defaults.
// A result waits in the output register; the next word is taken meanwhile
// and its result is held back only while the previous one is not taken.
`timescale 1ns / 1ps

module vblank_time_kalman_estimator #(
  parameter int TIME_BITS      = vtke_pkg::TIME_BITS_DEF,
  parameter int GAIN_FRAC_BITS = vtke_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  vtke_item_if.sink    items,
  vtke_result_if.source results,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  vtke_pkg::cfg_t      cfg;
  vtke_pkg::ctrl_cmd_t ctl;
  vtke_pkg::dp_stat_t  stat;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_period_ns    <= vtke_pkg::RST_INITIAL_PERIOD;
      cfg.process_noise_phase  <= vtke_pkg::RST_NOISE_PHASE;
      cfg.process_noise_period <= vtke_pkg::RST_NOISE_PERIOD;
      cfg.measurement_noise    <= vtke_pkg::RST_MEAS_NOISE;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        vtke_pkg::REG_INITIAL_PERIOD: cfg.initial_period_ns    <= pwdata[29:0];
        vtke_pkg::REG_NOISE_PHASE:    cfg.process_noise_phase  <= pwdata[39:0];
        vtke_pkg::REG_NOISE_PERIOD:   cfg.process_noise_period <= pwdata[39:0];
        default:                      cfg.measurement_noise    <= pwdata[49:0];
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      vtke_pkg::REG_INITIAL_PERIOD: prdata = 64'(cfg.initial_period_ns);
      vtke_pkg::REG_NOISE_PHASE:    prdata = 64'(cfg.process_noise_phase);
      vtke_pkg::REG_NOISE_PERIOD:   prdata = 64'(cfg.process_noise_period);
      default:                      prdata = 64'(cfg.measurement_noise);
    endcase
  end

  vtke_ctrl #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  vtke_dpath #(
    .TIME_BITS      (TIME_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctl           (ctl),
    .stat          (stat),
    .item_cmd      (items.cmd),
    .item_time     (items.vblank_time_ns),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .res_predicted (results.predicted_next_ns),
    .res_residual  (results.residual_ns),
    .res_period    (results.period_ns)
  );

endmodule

// ----- rtl/core/vtke_ctrl.sv -----
// Sequencer of the estimator: walks start, predict, gain divide and
// correction steps and drives the datapath by command words. Uses vtke_pkg.
`timescale 1ns / 1ps

module vtke_ctrl #(
  parameter int GAIN_FRAC_BITS = vtke_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  vtke_pkg::dp_stat_t  stat,
  output vtke_pkg::ctrl_cmd_t ctl
);

  localparam int CW = $clog2(GAIN_FRAC_BITS + 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(GAIN_FRAC_BITS - 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(GAIN_FRAC_BITS);

  vtke_pkg::ctrl_state_t state, state_next;
  logic [CW-1:0]         cnt;
  logic [2:0]            sel;

  // state register, step counter and operand select
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtke_pkg::ST_IDLE;
      cnt   <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      case (state)
        vtke_pkg::ST_MEAS: begin
          sel <= vtke_pkg::DSEL_K0;
        end
        vtke_pkg::ST_DIV_INIT, vtke_pkg::ST_MUL_INIT: begin
          cnt <= '0;
        end
        vtke_pkg::ST_DIV_STEP, vtke_pkg::ST_MUL_STEP: begin
          cnt <= cnt + CW'(1);
        end
        vtke_pkg::ST_DIV_END: begin
          sel <= (sel == vtke_pkg::DSEL_K0) ? vtke_pkg::DSEL_K1 : vtke_pkg::MSEL_K0_Y;
        end
        vtke_pkg::ST_MUL_END: begin
          sel <= sel + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vtke_pkg::ST_IDLE: begin
        if (item_valid) state_next = vtke_pkg::ST_DECODE;
      end
      vtke_pkg::ST_DECODE: begin
        case (stat.cmd)
          vtke_pkg::CMD_START:    state_next = vtke_pkg::ST_START0;
          vtke_pkg::CMD_MEASURED: state_next = vtke_pkg::ST_PRED0;
          vtke_pkg::CMD_MISSED:   state_next = vtke_pkg::ST_PRED0;
          default:                state_next = vtke_pkg::ST_OUT;
        endcase
      end
      vtke_pkg::ST_START0: state_next = vtke_pkg::ST_START1;
      vtke_pkg::ST_START1: state_next = vtke_pkg::ST_START2;
      vtke_pkg::ST_START2: state_next = vtke_pkg::ST_OUT;
      vtke_pkg::ST_PRED0:  state_next = vtke_pkg::ST_PRED1;
      vtke_pkg::ST_PRED1:  state_next = vtke_pkg::ST_PRED2;
      vtke_pkg::ST_PRED2:  state_next = vtke_pkg::ST_PRED3;
      vtke_pkg::ST_PRED3: begin
        state_next = (stat.cmd == vtke_pkg::CMD_MISSED) ? vtke_pkg::ST_MISS
                                                        : vtke_pkg::ST_MEAS;
      end
      vtke_pkg::ST_MISS:     state_next = vtke_pkg::ST_OUT;
      vtke_pkg::ST_MEAS:     state_next = vtke_pkg::ST_DIV_INIT;
      vtke_pkg::ST_DIV_INIT: state_next = vtke_pkg::ST_DIV_STEP;
      vtke_pkg::ST_DIV_STEP: begin
        if (cnt == DIV_LAST) state_next = vtke_pkg::ST_DIV_END;
      end
      vtke_pkg::ST_DIV_END: begin
        state_next = (sel == vtke_pkg::DSEL_K0) ? vtke_pkg::ST_DIV_INIT
                                                : vtke_pkg::ST_MUL_INIT;
      end
      vtke_pkg::ST_MUL_INIT: state_next = vtke_pkg::ST_MUL_STEP;
      vtke_pkg::ST_MUL_STEP: begin
        if (cnt == MUL_LAST) state_next = vtke_pkg::ST_MUL_END;
      end
      vtke_pkg::ST_MUL_END: begin
        state_next = (sel == vtke_pkg::MSEL_K1_HPR) ? vtke_pkg::ST_RESID
                                                    : vtke_pkg::ST_MUL_INIT;
      end
      vtke_pkg::ST_RESID: state_next = vtke_pkg::ST_OUT;
      vtke_pkg::ST_OUT: begin
        if (stat.out_free) state_next = vtke_pkg::ST_IDLE;
      end
      default: state_next = vtke_pkg::ST_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    item_ready = 1'b0;
    ctl.sel    = sel;
    ctl.op     = vtke_pkg::OP_NONE;
    case (state)
      vtke_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) ctl.op = vtke_pkg::OP_LOAD;
      end
      vtke_pkg::ST_START0:   ctl.op = vtke_pkg::OP_START0;
      vtke_pkg::ST_START1:   ctl.op = vtke_pkg::OP_START1;
      vtke_pkg::ST_START2:   ctl.op = vtke_pkg::OP_START2;
      vtke_pkg::ST_PRED0:    ctl.op = vtke_pkg::OP_PRED0;
      vtke_pkg::ST_PRED1:    ctl.op = vtke_pkg::OP_PRED1;
      vtke_pkg::ST_PRED2:    ctl.op = vtke_pkg::OP_PRED2;
      vtke_pkg::ST_PRED3:    ctl.op = vtke_pkg::OP_PRED3;
      vtke_pkg::ST_MISS:     ctl.op = vtke_pkg::OP_MISS;
      vtke_pkg::ST_MEAS:     ctl.op = vtke_pkg::OP_MEAS;
      vtke_pkg::ST_DIV_INIT: ctl.op = vtke_pkg::OP_DIV_INIT;
      vtke_pkg::ST_DIV_STEP: ctl.op = vtke_pkg::OP_DIV_STEP;
      vtke_pkg::ST_DIV_END:  ctl.op = vtke_pkg::OP_DIV_END;
      vtke_pkg::ST_MUL_INIT: ctl.op = vtke_pkg::OP_MUL_INIT;
      vtke_pkg::ST_MUL_STEP: ctl.op = vtke_pkg::OP_MUL_STEP;
      vtke_pkg::ST_MUL_END:  ctl.op = vtke_pkg::OP_MUL_END;
      vtke_pkg::ST_RESID:    ctl.op = vtke_pkg::OP_RESID;
      vtke_pkg::ST_OUT: begin
        if (stat.out_free) ctl.op = vtke_pkg::OP_OUT;
      end
      default: ctl.op = vtke_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- rtl/core/vtke_dpath.sv -----
// Datapath of the estimator: filter state, shared 32x32 multiplier for the
// start seeding, serial gain divider, serial gain multiplier, output word.
// Uses vtke_pkg.
`timescale 1ns / 1ps

module vtke_dpath #(
  parameter int TIME_BITS      = vtke_pkg::TIME_BITS_DEF,
  parameter int GAIN_FRAC_BITS = vtke_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  vtke_pkg::cfg_t                       cfg,
  input  vtke_pkg::ctrl_cmd_t                  ctl,
  output vtke_pkg::dp_stat_t                   stat,
  input  logic [vtke_pkg::CMD_W-1:0]           item_cmd,
  input  logic [vtke_pkg::TIME_W-1:0]          item_time,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [vtke_pkg::TIME_W-1:0]          res_predicted,
  output logic signed [vtke_pkg::RESID_W-1:0]  res_residual,
  output logic [vtke_pkg::PERIOD_W-1:0]        res_period
);

  localparam int GW = GAIN_FRAC_BITS + 2;
  localparam int AW = 64 + GAIN_FRAC_BITS;
  localparam int RESID_W_L = vtke_pkg::RESID_W;
  localparam int DIV10_HI = vtke_pkg::DIV10_SHIFT + 28;
  localparam logic [62:0] TMAX63 = 63'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
  localparam logic signed [GW-1:0] ONE_GAIN = {2'b01, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] RES_MAX = 64'sd1073741823;
  localparam logic signed [63:0] RES_MIN = -64'sd1073741824;

  // filter state
  logic [TIME_BITS-1:0]   phase;
  logic [30:0]            period;
  logic signed [63:0]     cov_pp, cov_pr, cov_rp, cov_rr;
  // captured word and working values
  logic [vtke_pkg::CMD_W-1:0] cmd;
  logic [62:0]            t;
  logic [28:0]            q10;
  logic signed [63:0]     acc_sum, hpp, hpr, hrp, hrr, y, s;
  logic [TIME_BITS-1:0]   xh;
  logic signed [GW-1:0]   k0, k1;
  logic signed [RESID_W_L-1:0] residual;
  // divider
  logic [63:0]            div_a;
  logic [GAIN_FRAC_BITS-1:0] div_q;
  logic                   div_big, div_neg;
  // gain multiplier
  logic [GAIN_FRAC_BITS:0] mul_g;
  logic [63:0]            mul_v;
  logic [AW-1:0]          mul_acc;
  logic                   mul_neg;

  // combinational helpers
  logic [TIME_BITS:0]     pred_sum;
  logic [TIME_BITS-1:0]   pred_val;
  logic [31:0]            m32_a, m32_b;
  logic [63:0]            m32_p;
  logic [63:0]            div_sh;
  logic                   div_ge;
  logic signed [63:0]     num, gain_val;
  logic signed [GW-1:0]   gain_sel, gain_new;
  logic [63:0]            rwide, rmag;
  logic signed [63:0]     mres, np, xs, rd;
  logic signed [63:0]     xh64, t64;

  function automatic logic [TIME_BITS-1:0] clamp_time(input logic signed [63:0] v);
    if (v[63]) begin
      clamp_time = '0;
    end else if (v[62:0] > TMAX63) begin
      clamp_time = TMAX;
    end else begin
      clamp_time = v[TIME_BITS-1:0];
    end
  endfunction

  function automatic logic [TIME_BITS-1:0] item_t_sat(input logic [62:0] v);
    item_t_sat = (v > TMAX63) ? TMAX : v[TIME_BITS-1:0];
  endfunction

  always_comb begin
    // predicted next vblank from the current state
    pred_sum = {1'b0, phase} + (TIME_BITS + 1)'(period);
    pred_val = pred_sum[TIME_BITS] ? TMAX : pred_sum[TIME_BITS-1:0];
    xh64     = $signed(64'(xh));
    t64      = $signed({1'b0, t});

    // shared multiplier for start seeding
    case (ctl.op)
      vtke_pkg::OP_START1: begin
        m32_a = 32'(cfg.initial_period_ns) + 32'd5;
        m32_b = vtke_pkg::DIV10_MULT;
      end
      vtke_pkg::OP_START2: begin
        m32_a = 32'(q10);
        m32_b = 32'(q10);
      end
      default: begin
        m32_a = 32'(cfg.initial_period_ns);
        m32_b = 32'(cfg.initial_period_ns);
      end
    endcase
    m32_p = m32_a * m32_b;

    // divider step and operand
    div_sh = {div_a[62:0], 1'b0};
    div_ge = div_sh >= s;
    num    = (ctl.sel == vtke_pkg::DSEL_K1) ? hrp : hpp;
    if (s[63] || (s == 64'sd0)) begin
      gain_new = '0;
    end else if (div_big) begin
      gain_new = div_neg ? -ONE_GAIN : ONE_GAIN;
    end else begin
      gain_new = div_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    end

    // multiplier operands
    case (ctl.sel)
      vtke_pkg::MSEL_K1_Y, vtke_pkg::MSEL_K1_HPP, vtke_pkg::MSEL_K1_HPR: gain_sel = k1;
      default: gain_sel = k0;
    endcase
    case (ctl.sel)
      vtke_pkg::MSEL_K0_Y, vtke_pkg::MSEL_K1_Y:     gain_val = y;
      vtke_pkg::MSEL_K0_HPP, vtke_pkg::MSEL_K1_HPP: gain_val = hpp;
      default:                                      gain_val = hpr;
    endcase

    // product scaled back, saturated and signed
    rwide = mul_acc[AW-1:GAIN_FRAC_BITS];
    rmag  = rwide[63] ? {1'b0, {63{1'b1}}} : rwide;
    mres  = mul_neg ? -$signed(rmag) : $signed(rmag);
    np    = vtke_pkg::sadd($signed(64'(period)), mres);
    xs    = vtke_pkg::sadd(xh64, mres);
    rd    = t64 - $signed(64'(phase));
  end

  assign stat.cmd      = cmd;
  assign stat.out_free = !res_valid || res_ready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.op == vtke_pkg::OP_OUT) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // filter state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      period <= '0;
      cov_pp <= '0;
      cov_pr <= '0;
      cov_rp <= '0;
      cov_rr <= '0;
    end else begin
      case (ctl.op)
        vtke_pkg::OP_START0: begin
          phase  <= (item_t_sat(t));
          period <= 31'(cfg.initial_period_ns);
          cov_pp <= $signed(m32_p);
          cov_pr <= '0;
          cov_rp <= '0;
        end
        vtke_pkg::OP_START2: begin
          cov_rr <= $signed(m32_p);
        end
        vtke_pkg::OP_MISS: begin
          phase  <= xh;
          cov_pp <= hpp;
          cov_pr <= hpr;
          cov_rp <= hrp;
          cov_rr <= hrr;
        end
        vtke_pkg::OP_MUL_END: begin
          case (ctl.sel)
            vtke_pkg::MSEL_K0_Y: phase <= clamp_time(xs);
            vtke_pkg::MSEL_K1_Y: begin
              if (np[63]) begin
                period <= '0;
              end else if (np > I32_MAX) begin
                period <= {31{1'b1}};
              end else begin
                period <= np[30:0];
              end
            end
            vtke_pkg::MSEL_K0_HPP: cov_pp <= vtke_pkg::sadd(hpp, -mres);
            vtke_pkg::MSEL_K0_HPR: cov_pr <= vtke_pkg::sadd(hpr, -mres);
            vtke_pkg::MSEL_K1_HPP: cov_rp <= vtke_pkg::sadd(hrp, -mres);
            default:               cov_rr <= vtke_pkg::sadd(hrr, -mres);
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      vtke_pkg::OP_LOAD: begin
        cmd      <= item_cmd;
        t        <= item_time;
        residual <= '0;
      end
      vtke_pkg::OP_START1: begin
        q10 <= m32_p[DIV10_HI:vtke_pkg::DIV10_SHIFT];
      end
      vtke_pkg::OP_PRED0: begin
        acc_sum <= vtke_pkg::sadd(cov_pp, cov_pr);
        hpr     <= vtke_pkg::sadd(cov_pr, cov_rr);
        hrp     <= vtke_pkg::sadd(cov_rp, cov_rr);
        hrr     <= vtke_pkg::sadd(cov_rr, $signed(64'(cfg.process_noise_period)));
        xh      <= pred_val;
      end
      vtke_pkg::OP_PRED1: acc_sum <= vtke_pkg::sadd(acc_sum, cov_rp);
      vtke_pkg::OP_PRED2: acc_sum <= vtke_pkg::sadd(acc_sum, cov_rr);
      vtke_pkg::OP_PRED3: begin
        hpp <= vtke_pkg::sadd(acc_sum, $signed(64'(cfg.process_noise_phase)));
        y   <= t64 - xh64;
      end
      vtke_pkg::OP_MEAS: begin
        s <= vtke_pkg::sadd(hpp, $signed(64'(cfg.measurement_noise)));
      end
      vtke_pkg::OP_DIV_INIT: begin
        div_a   <= vtke_pkg::mag64(num);
        div_big <= vtke_pkg::mag64(num) >= s;
        div_neg <= num[63];
        div_q   <= '0;
      end
      vtke_pkg::OP_DIV_STEP: begin
        div_a <= div_ge ? (div_sh - s) : div_sh;
        div_q <= {div_q[GAIN_FRAC_BITS-2:0], div_ge};
      end
      vtke_pkg::OP_DIV_END: begin
        if (ctl.sel == vtke_pkg::DSEL_K1) begin
          k1 <= gain_new;
        end else begin
          k0 <= gain_new;
        end
      end
      vtke_pkg::OP_MUL_INIT: begin
        mul_g   <= gain_sel[GW-1] ? (GAIN_FRAC_BITS + 1)'(-gain_sel)
                                  : gain_sel[GAIN_FRAC_BITS:0];
        mul_v   <= vtke_pkg::mag64(gain_val);
        mul_neg <= gain_sel[GW-1] ^ gain_val[63];
        mul_acc <= '0;
      end
      vtke_pkg::OP_MUL_STEP: begin
        mul_acc <= {mul_acc[AW-2:0], 1'b0} + (mul_g[GAIN_FRAC_BITS] ? AW'(mul_v) : AW'(0));
        mul_g   <= {mul_g[GAIN_FRAC_BITS-1:0], 1'b0};
      end
      vtke_pkg::OP_RESID: begin
        if (rd > RES_MAX) begin
          residual <= RESID_W_L'(RES_MAX);
        end else if (rd < RES_MIN) begin
          residual <= RESID_W_L'(RES_MIN);
        end else begin
          residual <= rd[RESID_W_L-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (ctl.op == vtke_pkg::OP_OUT) begin
      res_predicted <= vtke_pkg::TIME_W'(pred_val);
      res_residual  <= residual;
      res_period    <= period[30] ? {vtke_pkg::PERIOD_W{1'b1}} : period[29:0];
    end
  end

endmodule
